### rtl/brfr_pkg.sv
// Shared types, codes and constants for the buffer feedback rate reporter.
package brfr_pkg;

	localparam int unsigned COUNT_W    = 11;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned LEVEL_W    = 2;
	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned IDENT_W    = 32;
	localparam int unsigned PORT_W     = 16;
	localparam int unsigned CHAN_W     = 16;
	localparam int unsigned TICKS_W    = 3;
	localparam int unsigned FAIL_W     = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned RING_DEPTH_DEF = 1024;
	localparam int unsigned PCT_MAX        = 100;

	localparam logic [TICKS_W-1:0] SINCE_MAX     = 3'd7;
	localparam logic [FAIL_W-1:0]  FAIL_LIMIT    = 2'd3;
	localparam logic [TICKS_W-1:0] INTERVAL_FAST = 3'd1;
	localparam logic [TICKS_W-1:0] INTERVAL_MOD  = 3'd2;
	localparam logic [TICKS_W-1:0] INTERVAL_SLOW = 3'd3;

	localparam logic [PCT_W-1:0]   MAJOR_RST    = 7'd75;
	localparam logic [PCT_W-1:0]   MODERATE_RST = 7'd50;
	localparam logic [PCT_W-1:0]   INCREASE_RST = 7'd25;
	localparam logic [TICKS_W-1:0] PAUSE_RST    = 3'd1;
	localparam logic [SEQ_W-1:0]   SEQ_RST      = 32'd1;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_INCREASE = 2'd1,
		LVL_MODERATE = 2'd2,
		LVL_MAJOR    = 2'd3
	} level_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPORT_ENABLE = 3'd0,
		CFG_MAJOR_TH      = 3'd1,
		CFG_MODERATE_TH   = 3'd2,
		CFG_INCREASE_TH   = 3'd3,
		CFG_PAUSE_TICKS   = 3'd4,
		CFG_SERVER_IP     = 3'd5,
		CFG_SERVER_PORT   = 3'd6,
		CFG_CHANNEL       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] buffer_count;
		logic               link_ok;
	} tick_t;

	typedef struct packed {
		logic [IDENT_W-1:0] client_ident;
		logic [CHAN_W-1:0]  channel_out;
		logic [LEVEL_W-1:0] level_code;
		logic [PCT_W-1:0]   usage_percent;
		logic [SEQ_W-1:0]   sequence_number;
		logic               send_succeeded;
	} report_t;

	typedef struct packed {
		logic    produce;
		report_t result;
	} decision_t;

endpackage

### rtl/brfr_usage.sv
// Ring occupancy to whole usage percent by exact reciprocal multiplication.
module brfr_usage import brfr_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic [COUNT_W-1:0] buffer_count,
	output logic [PCT_W-1:0]   usage
);

	localparam int unsigned    XW    = COUNT_W + PCT_W;
	localparam int unsigned    LG    = $clog2(RING_DEPTH);
	localparam int unsigned    SH    = XW + LG;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam longint unsigned SCALE = RECIP * 64'(PCT_MAX);
	localparam int unsigned    SW    = $clog2(SCALE + 64'd1);
	localparam int unsigned    PW    = COUNT_W + SW;

	logic [PW-1:0] prod;
	logic [PW-1:0] quot;
	logic          full;

	always_comb begin
		prod = PW'(buffer_count) * PW'(SCALE);
		quot = prod >> SH;
		full = 32'(buffer_count) >= 32'(RING_DEPTH);
		usage = full ? PCT_W'(PCT_MAX) : quot[PCT_W-1:0];
	end

endmodule

### rtl/brfr_ctrl.sv
// Configuration registers, report scheduling state and per-tick decision.
module brfr_ctrl import brfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	input  logic [PCT_W-1:0]      usage,
	input  logic                  link_ok,
	output decision_t             decision
);

	logic                 report_enable_q;
	logic [PCT_W-1:0]     major_th_q;
	logic [PCT_W-1:0]     moderate_th_q;
	logic [PCT_W-1:0]     increase_th_q;
	logic [TICKS_W-1:0]   pause_ticks_q;
	logic [IDENT_W-1:0]   server_ip_q;
	logic [PORT_W-1:0]    server_port_q;
	logic [CHAN_W-1:0]    channel_q;

	logic [SEQ_W-1:0]     next_seq_q;
	level_t               reported_level_q;
	logic [TICKS_W-1:0]   since_q;
	logic [FAIL_W-1:0]    fail_q;
	logic [TICKS_W-1:0]   pause_q;

	logic [TICKS_W-1:0]   since_inc;
	level_t               level;
	logic [TICKS_W-1:0]   interval;
	logic                 paused;
	logic [FAIL_W-1:0]    fail_inc;

	always_comb begin
		since_inc = (since_q < SINCE_MAX) ? since_q + TICKS_W'(1) : since_q;
		paused = pause_q != '0;
		fail_inc = fail_q + FAIL_W'(1);

		priority if (usage > major_th_q) begin
			level = LVL_MAJOR;
		end else if (usage > moderate_th_q) begin
			level = LVL_MODERATE;
		end else if (usage < increase_th_q) begin
			level = LVL_INCREASE;
		end else begin
			level = LVL_NORMAL;
		end

		priority if (level != reported_level_q || level == LVL_MAJOR) begin
			interval = INTERVAL_FAST;
		end else if (level == LVL_MODERATE) begin
			interval = INTERVAL_MOD;
		end else begin
			interval = INTERVAL_SLOW;
		end

		decision.produce = !paused && report_enable_q && (since_inc >= interval);
		decision.result.client_ident    = server_ip_q ^ IDENT_W'(server_port_q);
		decision.result.channel_out     = channel_q;
		decision.result.level_code      = level;
		decision.result.usage_percent   = usage;
		decision.result.sequence_number = next_seq_q;
		decision.result.send_succeeded  = link_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q <= 1'b1;
			major_th_q      <= MAJOR_RST;
			moderate_th_q   <= MODERATE_RST;
			increase_th_q   <= INCREASE_RST;
			pause_ticks_q   <= PAUSE_RST;
			server_ip_q     <= '0;
			server_port_q   <= '0;
			channel_q       <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_REPORT_ENABLE: report_enable_q <= cfg_data[0];
				CFG_MAJOR_TH:      major_th_q      <= cfg_data[PCT_W-1:0];
				CFG_MODERATE_TH:   moderate_th_q   <= cfg_data[PCT_W-1:0];
				CFG_INCREASE_TH:   increase_th_q   <= cfg_data[PCT_W-1:0];
				CFG_PAUSE_TICKS:   pause_ticks_q   <= cfg_data[TICKS_W-1:0];
				CFG_SERVER_IP:     server_ip_q     <= cfg_data[IDENT_W-1:0];
				CFG_SERVER_PORT:   server_port_q   <= cfg_data[PORT_W-1:0];
				CFG_CHANNEL:       channel_q       <= cfg_data[CHAN_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q       <= SEQ_RST;
			reported_level_q <= LVL_NORMAL;
			since_q          <= SINCE_MAX;
			fail_q           <= '0;
			pause_q          <= '0;
		end else if (step) begin
			since_q <= since_inc;
			if (paused) begin
				pause_q <= pause_q - TICKS_W'(1);
			end else if (decision.produce) begin
				next_seq_q <= next_seq_q + SEQ_W'(1);
				if (link_ok) begin
					since_q          <= '0;
					reported_level_q <= level;
				end else if (fail_inc >= FAIL_LIMIT) begin
					fail_q  <= '0;
					pause_q <= pause_ticks_q;
				end else begin
					fail_q <= fail_inc;
				end
			end
		end
	end

	// the pause counter only loads on a failed attempt, which needs a live report
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && paused) |-> !decision.produce)
		else $error("report decided during pause");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && decision.produce) |=> next_seq_q == $past(next_seq_q) + SEQ_W'(1))
		else $error("sequence did not advance on report");
	assert property (@(posedge clk) disable iff (!arst_n)
		fail_q != FAIL_LIMIT)
		else $error("failure count passed its limit");

endmodule

### rtl/buffer_feedback_rate_reporter.sv
// Top level of the buffer feedback rate reporter: request and report registers.
// Each tick request carries the ring occupancy and link status; the block turns
// the occupancy into a whole percent at the input register, classifies it
// against the three thresholds and decides in the next cycle whether a report
// is due, producing zero or one report per tick. A request passes through the
// input register and then the report register, and a new request is taken every
// cycle while the report register drains; the loop through the scheduling state
// sets that rate. Configuration writes are always accepted and are registered.
module buffer_feedback_rate_reporter import brfr_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_ready,
	input  tick_t                 tick,
	output logic                  report_valid,
	input  logic                  report_ready,
	output report_t               report,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic             tick_valid_s1;
	logic [PCT_W-1:0] usage_s1;
	logic             link_s1;
	logic             report_valid_q;
	report_t          report_q;

	logic [PCT_W-1:0] usage_in;
	decision_t        decision;
	logic             slot_free;
	logic             advance;

	brfr_usage #(
		.RING_DEPTH(RING_DEPTH)
	) u_usage (
		.buffer_count(tick.buffer_count),
		.usage       (usage_in)
	);

	brfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (advance),
		.usage    (usage_s1),
		.link_ok  (link_s1),
		.decision (decision)
	);

	assign cfg_ready    = 1'b1;
	assign slot_free    = !report_valid_q || report_ready;
	assign advance      = tick_valid_s1 && (!decision.produce || slot_free);
	assign tick_ready   = !tick_valid_s1 || advance;
	assign report_valid = report_valid_q;
	assign report       = report_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			tick_valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			usage_s1 <= usage_in;
			link_s1  <= tick.link_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (advance && decision.produce) begin
			report_valid_q <= 1'b1;
		end else if (report_ready) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && decision.produce) begin
			report_q <= decision.result;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid_s1 |-> usage_s1 <= PCT_W'(PCT_MAX))
		else $error("usage above full scale");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && decision.produce) |=> report_valid_q)
		else $error("decided report not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid_q && !report_ready) |=> $stable(report_q) || !advance)
		else $error("stalled report overwritten");

endmodule
